### hdl/biw_pkg.sv
`timescale 1ns / 1ps

package biw_pkg;

    // Store geometry and fixed-point format
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int FRAC_BITS  = 8;

    // Field widths
    localparam int POS_W  = 8;
    localparam int CHAN_W = 8;
    localparam int DISP_W = 16;
    localparam int CFG_W  = 9;
    localparam int PIX_W  = 3 * CHAN_W;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    // Item actions
    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    typedef struct packed {
        logic                     action;
        logic [POS_W-1:0]         pos_x;
        logic [POS_W-1:0]         pos_y;
        logic [CHAN_W-1:0]        red_in;
        logic [CHAN_W-1:0]        green_in;
        logic [CHAN_W-1:0]        blue_in;
        logic signed [DISP_W-1:0] disp_x;
        logic signed [DISP_W-1:0] disp_y;
    } biw_req_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red_out;
        logic [CHAN_W-1:0] green_out;
        logic [CHAN_W-1:0] blue_out;
        logic              outside;
    } biw_rsp_t;

endpackage

### hdl/bilinear_image_warp_unit.sv
// Bilinear image warp: pixel store in four parity banks, one item per cycle unless stalled.
// Pipeline: a sample's result reaches the output register after the bank read at
// acceptance, the vertical blend and the horizontal blend; loads give no result.
// Throughput: one item per cycle unless stalled, set by the single read port per bank.
// Reset: pipeline valids clear, image_width and image_height return to 256;
// the pixel store is not cleared and holds undefined data until written.
`timescale 1ns / 1ps

module bilinear_image_warp_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_stall,
    input  biw_pkg::biw_req_t                req_item,
    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output biw_pkg::biw_rsp_t                rsp_item,
    input  logic                             cfg_write,
    input  logic [biw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [biw_pkg::CFG_W-1:0]        cfg_data
);
    import biw_pkg::*;

    localparam int X_W        = $clog2(MAX_WIDTH);
    localparam int Y_W        = $clog2(MAX_HEIGHT);
    localparam int DISP_INT_W = DISP_W - FRAC_BITS;
    localparam int COORD_W    = ((POS_W > DISP_INT_W) ? POS_W : DISP_INT_W) + 2;
    localparam int BA_W       = (X_W - 1) + (Y_W - 1);
    localparam int BANK_DEPTH = 2 ** BA_W;
    localparam int WT_W       = FRAC_BITS + 1;
    localparam int L_W        = CHAN_W + FRAC_BITS;
    localparam int SUM_W      = WT_W + L_W;
    localparam logic [WT_W-1:0] ONE_WT = WT_W'(2 ** FRAC_BITS);

    // Configuration registers
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_W'(256);
            height_reg <= CFG_W'(256);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline flow control: each stage moves when the next one is free or moving
    logic s1_v_reg, s2_v_reg, rsp_v_reg;
    logic en_o, en2, en1, req_acc, smp_acc, ld_acc;

    assign en_o      = !rsp_v_reg || !rsp_stall;
    assign en2       = !s2_v_reg || en_o;
    assign en1       = !s1_v_reg || en2;
    assign req_stall = !en1;
    assign req_acc   = req_valid && en1;
    assign smp_acc   = req_acc && (req_item.action == ACT_SAMPLE);
    assign ld_acc    = req_acc && (req_item.action == ACT_LOAD);

    // Coordinate split: floor is pos plus integer part of disp, fraction is the low bits
    logic [CFG_W-1:0]         w_eff, h_eff;
    logic signed [COORD_W-1:0] fu, fv, cu, cv;
    logic [FRAC_BITS-1:0]     du, dv;
    logic                     outside_c;

    always_comb
    begin
        w_eff = (32'(width_reg) > 32'(MAX_WIDTH)) ? CFG_W'(MAX_WIDTH) : width_reg;
        h_eff = (32'(height_reg) > 32'(MAX_HEIGHT)) ? CFG_W'(MAX_HEIGHT) : height_reg;
        du = req_item.disp_x[FRAC_BITS-1:0];
        dv = req_item.disp_y[FRAC_BITS-1:0];
        fu = $signed({{(COORD_W-POS_W){1'b0}}, req_item.pos_x})
           + $signed({{(COORD_W-DISP_INT_W){req_item.disp_x[DISP_W-1]}},
                      req_item.disp_x[DISP_W-1:FRAC_BITS]});
        fv = $signed({{(COORD_W-POS_W){1'b0}}, req_item.pos_y})
           + $signed({{(COORD_W-DISP_INT_W){req_item.disp_y[DISP_W-1]}},
                      req_item.disp_y[DISP_W-1:FRAC_BITS]});
        cu = fu + $signed(COORD_W'(du != '0));
        cv = fv + $signed(COORD_W'(dv != '0));
        outside_c = fu[COORD_W-1] || fv[COORD_W-1]
                 || (cu >= $signed({{(COORD_W-CFG_W){1'b0}}, w_eff}))
                 || (cv >= $signed({{(COORD_W-CFG_W){1'b0}}, h_eff}));
    end

    // Load target: bank by coordinate parity, address by the remaining bits
    logic            ld_in_store;
    logic [1:0]      ld_bank;
    logic [BA_W-1:0] ld_addr;
    logic [PIX_W-1:0] ld_pix;

    always_comb
    begin
        ld_in_store = (32'(req_item.pos_x) < 32'(MAX_WIDTH))
                   && (32'(req_item.pos_y) < 32'(MAX_HEIGHT));
        ld_bank = {req_item.pos_y[0], req_item.pos_x[0]};
        ld_addr = {req_item.pos_y[Y_W-1:1], req_item.pos_x[X_W-1:1]};
        ld_pix  = {req_item.blue_in, req_item.green_in, req_item.red_in};
    end

    // Four pixel banks; bank index is {row parity, column parity}
    logic [PIX_W-1:0] rd_reg [4];

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        logic [PIX_W-1:0]   mem [BANK_DEPTH];
        logic [COORD_W-1:0] rx, ry;
        logic [BA_W-1:0]    rd_addr;

        // this bank holds the neighbor whose parity matches; step by one if needed
        always_comb
        begin
            rx = fu + COORD_W'(fu[0] ^ b[0]);
            ry = fv + COORD_W'(fv[0] ^ b[1]);
            rd_addr = {ry[Y_W-1:1], rx[X_W-1:1]};
        end

        always_ff @(posedge clk)
        begin
            if (ld_acc && ld_in_store && (ld_bank == 2'(b)))
            begin
                mem[ld_addr] <= ld_pix;
            end
            if (smp_acc)
            begin
                rd_reg[b] <= mem[rd_addr];
            end
        end
    end

    // Stage 1 control
    logic                 s1_out_reg, s1_fx_reg, s1_fy_reg;
    logic [FRAC_BITS-1:0] s1_du_reg, s1_dv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else if (en1)
        begin
            s1_v_reg <= smp_acc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_out_reg <= outside_c;
            s1_fx_reg  <= fu[0];
            s1_fy_reg  <= fv[0];
            s1_du_reg  <= du;
            s1_dv_reg  <= dv;
        end
    end

    // Stage 1: pick neighbors, blend vertically
    logic [PIX_W-1:0] nb_a, nb_b, nb_c, nb_d;
    logic [WT_W-1:0]  wv0, wv1;
    logic [L_W-1:0]   left_next [3];
    logic [L_W-1:0]   right_next [3];

    always_comb
    begin
        nb_a = rd_reg[{s1_fy_reg, s1_fx_reg}];
        // a zero fraction collapses the far neighbor onto the near one
        nb_b = (s1_dv_reg != '0) ? rd_reg[{~s1_fy_reg, s1_fx_reg}] : nb_a;
        nb_c = (s1_du_reg != '0) ? rd_reg[{s1_fy_reg, ~s1_fx_reg}] : nb_a;
        if (s1_du_reg == '0)
        begin
            nb_d = nb_b;
        end
        else if (s1_dv_reg == '0)
        begin
            nb_d = nb_c;
        end
        else
        begin
            nb_d = rd_reg[{~s1_fy_reg, ~s1_fx_reg}];
        end
        wv1 = {1'b0, s1_dv_reg};
        wv0 = ONE_WT - wv1;
        for (int k = 0; k < 3; k++)
        begin
            left_next[k]  = L_W'(wv0 * nb_a[CHAN_W*k +: CHAN_W]
                               + wv1 * nb_b[CHAN_W*k +: CHAN_W]);
            right_next[k] = L_W'(wv0 * nb_c[CHAN_W*k +: CHAN_W]
                               + wv1 * nb_d[CHAN_W*k +: CHAN_W]);
        end
    end

    // Stage 2 registers
    logic                 s2_out_reg;
    logic [FRAC_BITS-1:0] s2_du_reg;
    logic [L_W-1:0]       left_reg [3];
    logic [L_W-1:0]       right_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg <= 1'b0;
        end
        else if (en2)
        begin
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_out_reg <= s1_out_reg;
            s2_du_reg  <= s1_du_reg;
            left_reg   <= left_next;
            right_reg  <= right_next;
        end
    end

    // Stage 2: blend horizontally and truncate, or give black for an outside sample
    logic [WT_W-1:0]   wu0, wu1;
    logic [SUM_W-1:0]  sum [3];
    biw_rsp_t          rsp_next;

    always_comb
    begin
        wu1 = {1'b0, s2_du_reg};
        wu0 = ONE_WT - wu1;
        for (int k = 0; k < 3; k++)
        begin
            sum[k] = SUM_W'(wu0 * left_reg[k] + wu1 * right_reg[k]);
        end
        if (s2_out_reg)
        begin
            rsp_next = '{red_out: '0, green_out: '0, blue_out: '0, outside: 1'b1};
        end
        else
        begin
            rsp_next.red_out   = sum[0][2*FRAC_BITS +: CHAN_W];
            rsp_next.green_out = sum[1][2*FRAC_BITS +: CHAN_W];
            rsp_next.blue_out  = sum[2][2*FRAC_BITS +: CHAN_W];
            rsp_next.outside   = 1'b0;
        end
    end

    // Output register
    biw_rsp_t rsp_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_v_reg <= 1'b0;
        end
        else if (en_o)
        begin
            rsp_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_o)
        begin
            rsp_item_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_v_reg;
    assign rsp_item  = rsp_item_reg;

endmodule

### hdl/biw_checker.sv
`timescale 1ns / 1ps

module biw_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    input  logic                          req_stall,
    input  biw_pkg::biw_req_t             req_item,
    input  logic                          rsp_valid,
    input  logic                          rsp_stall,
    input  biw_pkg::biw_rsp_t             rsp_item
);
    import biw_pkg::*;

    // a stalled input item stays offered and unchanged
    a_req_stable: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_stall |=> req_valid && $stable(req_item))
        else $error("input item changed while stalled");

    // a stalled result stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("result item dropped while stalled");

    // a stalled result keeps its payload
    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> $stable(rsp_item))
        else $error("result item changed while stalled");

    // outside samples come out black
    a_outside_black: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_item.outside |->
            (rsp_item.red_out == '0) && (rsp_item.green_out == '0)
            && (rsp_item.blue_out == '0))
        else $error("outside result is not black");

    // with no result waiting, the input side is never held off
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> !req_stall)
        else $error("input stalled with empty output");

endmodule

bind bilinear_image_warp_unit biw_checker u_biw_checker (.*);
